/* rtl/sobel_edge_magnitude_rgb_macros.svh */
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// same-cycle implication, checked out of reset
`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sem_pkg.sv */
// shared constants and types of the sobel edge magnitude block
`default_nettype none
package sem_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int AW   = $clog2(MAX_WIDTH);        // column / line store address
  localparam int CW   = 11;                       // image_width register
  localparam int HW   = 13;                       // image_height register
  localparam int RW   = $clog2(MAX_HEIGHT);       // row of a result
  localparam int PW   = 23;                       // raster position, runs past the frame
  localparam int PIXW = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int NLANE = 3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } mask_t;

  typedef logic [8:0][7:0] win_t;   // row-major, entry k*3+l
endpackage
`default_nettype wire

/* rtl/sem_if.sv */
// stream and configuration channel interfaces
`default_nettype none
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, op, in_red, in_green, in_blue, input ready);
  modport sink (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/sem_line_store.sv */
// two line stores sharing one address, registered read
`default_nettype none
module sem_line_store
  import sem_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [2*PIXW-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [2*PIXW-1:0] wr_data
);
  // upper half: two rows above, lower half: row above
  logic [2*PIXW-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* rtl/sem_lane.sv */
// one color lane: sobel gradients, sum of squares, bit-serial rounded root
`default_nettype none
module sem_lane
  import sem_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire win_t       win,
  input  wire mask_t      mask,
  output logic            done,
  output logic [7:0]      root
);
  logic [20:0] s_r, s_nxt;
  logic [7:0]  n_r, n_nxt;
  logic [3:0]  step_r, step_nxt;

  always_comb begin
    logic [7:0]         v [9];
    logic signed [11:0] gx, gy;
    logic signed [23:0] sqx, sqy;
    logic [7:0]         bitv, t;
    logic [15:0]        prod;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        v[k*3+l] = ((k == 0 && !mask.top_ok) || (k == 2 && !mask.bot_ok) ||
                    (l == 0 && !mask.left_ok) || (l == 2 && !mask.right_ok))
                   ? 8'd0 : win[k*3+l];
      end
    end
    gx = $signed({4'd0, v[2]}) + $signed({3'd0, v[5], 1'b0}) + $signed({4'd0, v[8]})
       - $signed({4'd0, v[0]}) - $signed({3'd0, v[3], 1'b0}) - $signed({4'd0, v[6]});
    gy = $signed({4'd0, v[6]}) + $signed({3'd0, v[7], 1'b0}) + $signed({4'd0, v[8]})
       - $signed({4'd0, v[0]}) - $signed({3'd0, v[1], 1'b0}) - $signed({4'd0, v[2]});
    sqx = gx * gx;
    sqy = gy * gy;
    bitv = 8'd1 << (step_r - 4'd1);
    t    = n_r | bitv;
    prod = {8'd0, t} * ({8'd0, t} - 16'd1);

    s_nxt    = s_r;
    n_nxt    = n_r;
    step_nxt = step_r;
    if (start) begin
      s_nxt    = sqx[20:0] + sqy[20:0];
      n_nxt    = 8'd0;
      step_nxt = 4'd8;
    end else if (step_r != 4'd0) begin
      // largest n with n*(n-1) < s gives the root rounded half up
      if ({5'd0, prod} < s_r) begin
        n_nxt = t;
      end
      step_nxt = step_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
    end else begin
      step_r <= step_nxt;
    end
    s_r <= s_nxt;
    n_r <= n_nxt;
  end

  assign done = (step_r == 4'd0);
  assign root = n_r;
endmodule
`default_nettype wire

/* rtl/sobel_edge_magnitude_rgb.sv */
// top level of the sobel edge magnitude block
// Takes RGB pixels of one frame in raster order on in_ch and returns per-channel
// clamped Sobel gradient magnitudes on out_ch (valid/ready, a beat moves when
// both are high). cfg_ch writes image_width (index 0) and image_height (index 1);
// a write to either aborts the frame in progress.
// The result for pixel q leaves with the pixel at q + width + 1; after the last
// pixel, each flush beat (op = 1) yields one owed result, frame_end marks the last.
// Pixel beats arriving while results are owed are taken and dropped.
// An item goes from acceptance to its result in the output register through
// one window push, one gradient step, eight bit-serial square root steps run
// side by side in the three color lanes, a check that the lanes are done and
// the load of the output register. Input is taken again once back in idle; a
// pixel that gives no result only pushes the window.
// The first flush of a one-row frame pushes two columns.
// A beat that causes nothing (dropped pixel, flush with nothing owed) leaves the block idle.
// The output register holds a result while the receiver stalls; the next item is
// accepted meanwhile, and its result waits until that register is free.
// Reset (rst_n low, synchronous) restores 640 x 480 and clears the position;
// the line stores need no clearing, unwritten entries only feed masked taps.
`default_nettype none
`include "sobel_edge_magnitude_rgb_macros.svh"
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sem_in_if.sink    in_ch,
  sem_out_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUSH   = 3'd1;
  localparam logic [2:0] S_REREAD = 3'd2;
  localparam logic [2:0] S_CALC   = 3'd3;
  localparam logic [2:0] S_ROOT   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  width_r, width_nxt;
  logic [HW-1:0]  height_r, height_nxt;
  logic [PW-1:0]  total_r;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  col_r, col_nxt;
  logic [AW-1:0]  rc_r, rc_nxt;
  logic [RW-1:0]  rr_r, rr_nxt;
  logic [CW-1:0]  pend_r, pend_nxt;
  logic           mode_r, mode_nxt;
  logic [PIXW-1:0] px_r, px_nxt;
  logic [PIXW-1:0] win_r [9];
  logic [PIXW-1:0] win_nxt [9];
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_red_r, out_green_r, out_blue_r;
  logic           out_end_r;
  logic           load_out;

  logic [CW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic           in_acc, cfg_acc;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr;
  logic [2*PIXW-1:0] rd_data;
  logic           lane_start;
  mask_t          mask;
  win_t           lane_win [NLANE];
  logic [NLANE-1:0] lane_done;
  logic [7:0]     lane_root [NLANE];

  assign w_eff = (width_r == '0) ? CW'(1)
               : (width_r > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? HW'(1)
               : (height_r > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : height_r;

  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign rd_en   = in_acc || (state_r == S_REREAD);
  assign rd_addr = col_r;
  assign wr_en   = (state_r == S_PUSH);

  sem_line_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (col_r),
    .wr_data ({rd_data[PIXW-1:0], px_r})
  );

  // masks from the raster position of the result
  always_comb begin
    mask.top_ok   = (rr_r != '0);
    mask.bot_ok   = ({1'b0, rr_r} + HW'(1)) < h_eff;
    mask.left_ok  = (rc_r != '0);
    mask.right_ok = ({1'b0, rc_r} + CW'(1)) < w_eff;
  end

  assign lane_start = (state_r == S_CALC);

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    always_comb begin
      for (int e = 0; e < 9; e++) begin
        lane_win[g][e] = win_r[e][PIXW-1-8*g -: 8];
      end
    end
    sem_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .win   (lane_win[g]),
      .mask  (mask),
      .done  (lane_done[g]),
      .root  (lane_root[g])
    );
  end

  always_comb begin
    logic [PW-1:0] q;
    logic [PW-1:0] w_ext;
    logic          adv_last;
    w_ext = {{(PW-CW){1'b0}}, w_eff};
    q     = total_r - {{(PW-CW){1'b0}}, pend_r};
    adv_last = ({1'b0, col_r} + CW'(1)) >= w_eff;

    state_nxt  = state_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pos_nxt    = pos_r;
    col_nxt    = col_r;
    rc_nxt     = rc_r;
    rr_nxt     = rr_r;
    pend_nxt   = pend_r;
    mode_nxt   = mode_r;
    px_nxt     = px_r;
    win_nxt    = win_r;
    load_out   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_ch.index == REG_WIDTH || cfg_ch.index == REG_HEIGHT) begin
            if (cfg_ch.index == REG_WIDTH) begin
              width_nxt = cfg_ch.data[CW-1:0];
            end else begin
              height_nxt = cfg_ch.data[HW-1:0];
            end
            pos_nxt  = '0;
            col_nxt  = '0;
            rc_nxt   = '0;
            rr_nxt   = '0;
            pend_nxt = '0;
          end
        end else if (in_acc) begin
          mode_nxt = in_ch.op;
          px_nxt   = (in_ch.op == OP_FLUSH) ? '0 : {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
          // dropped pixel or idle flush stay in idle, only op and pixel are latched
          if ((in_ch.op == OP_PIXEL && pend_r == '0) ||
              (in_ch.op == OP_FLUSH && pend_r != '0)) begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        for (int k = 0; k < 3; k++) begin
          win_nxt[k*3]   = win_r[k*3+1];
          win_nxt[k*3+1] = win_r[k*3+2];
        end
        win_nxt[2] = rd_data[2*PIXW-1:PIXW];
        win_nxt[5] = rd_data[PIXW-1:0];
        win_nxt[8] = px_r;
        pos_nxt = pos_r + PW'(1);
        col_nxt = adv_last ? '0 : col_r + AW'(1);
        if (mode_r == OP_PIXEL) begin
          if (pos_r + PW'(1) >= total_r) begin
            pend_nxt = (total_r < w_ext + PW'(1)) ? total_r[CW-1:0] : w_eff + CW'(1);
          end
          state_nxt = (pos_r >= w_ext + PW'(1)) ? S_CALC : S_IDLE;
        end else begin
          state_nxt = (pos_r >= q + w_ext + PW'(1)) ? S_CALC : S_REREAD;
        end
      end
      S_REREAD: begin
        state_nxt = S_PUSH;
      end
      S_CALC: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (&lane_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (({1'b0, rc_r} + CW'(1)) >= w_eff) begin
            rc_nxt = '0;
            rr_nxt = rr_r + RW'(1);
          end else begin
            rc_nxt = rc_r + AW'(1);
          end
          if (mode_r == OP_FLUSH) begin
            pend_nxt = pend_r - CW'(1);
            if (pend_r == CW'(1)) begin
              pos_nxt = '0;
              col_nxt = '0;
              rc_nxt  = '0;
              rr_nxt  = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= CW'(640);
      height_r    <= HW'(480);
      pos_r       <= '0;
      col_r       <= '0;
      rc_r        <= '0;
      rr_r        <= '0;
      pend_r      <= '0;
      mode_r      <= OP_PIXEL;
      out_valid_r <= 1'b0;
      for (int e = 0; e < 9; e++) begin
        win_r[e] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      pos_r       <= pos_nxt;
      col_r       <= col_nxt;
      rc_r        <= rc_nxt;
      rr_r        <= rr_nxt;
      pend_r      <= pend_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
    px_r    <= px_nxt;
    total_r <= PW'(w_eff) * PW'(h_eff);
    if (load_out) begin
      out_red_r   <= lane_root[0];
      out_green_r <= lane_root[1];
      out_blue_r  <= lane_root[2];
      out_end_r   <= (mode_r == OP_FLUSH) && (pend_r == CW'(1));
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_red   = out_red_r;
  assign out_ch.edge_green = out_green_r;
  assign out_ch.edge_blue  = out_blue_r;
  assign out_ch.frame_end  = out_end_r;

  `SEM_ASSERT_NEXT(a_emit_fills_out, (state_r == S_EMIT) && !out_valid_r, out_valid_r, "result not loaded into output register")
  `SEM_ASSERT_NEXT(a_cfg_aborts, cfg_acc && (cfg_ch.index == REG_WIDTH || cfg_ch.index == REG_HEIGHT), (pend_r == '0) && (pos_r == '0), "register write did not abort the frame")
  `SEM_ASSERT_NOW(a_no_input_while_busy, (state_r != S_IDLE), !in_ch.ready && !cfg_ch.ready, "channel ready while an item is in flight")
endmodule
`default_nettype wire
